// ===== hw/rtl/upmq_pkg.sv =====
// ----------------------------------------------------------------------------
// upmq_pkg: shared types for the unique priority max queue
// Command and status codes, controller states and the cell control word.
// ----------------------------------------------------------------------------
package upmq_pkg;

   typedef enum logic [1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_PEEK = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_DUP   = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CMP,
      FSM_EXEC
   } fsm_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

   localparam int unsigned PRIO_PORT_BITS  = 16;
   localparam int unsigned DATA_PORT_BITS  = 32;
   localparam int unsigned TOTAL_PORT_BITS = 5;

endpackage

// ===== hw/rtl/upmq_cell.sv =====
// ----------------------------------------------------------------------------
// upmq_cell: one slot of the sorted chain
// Holds a priority, a data word and a valid bit. Registers its compare
// against the pending item, then inserts, pops or holds as told.
// ----------------------------------------------------------------------------
module upmq_cell #(
   parameter int unsigned PRIO_BITS = 16,
   parameter int unsigned DATA_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  upmq_pkg::cell_ctl_type ctl,
   input  logic [PRIO_BITS-1:0]  new_prio,
   input  logic [DATA_BITS-1:0]  new_data,
   input  logic [PRIO_BITS-1:0]  left_prio,
   input  logic [DATA_BITS-1:0]  left_data,
   input  logic                  left_valid,
   input  logic                  left_gt,
   input  logic [PRIO_BITS-1:0]  right_prio,
   input  logic [DATA_BITS-1:0]  right_data,
   input  logic                  right_valid,
   output logic [PRIO_BITS-1:0]  prio,
   output logic [DATA_BITS-1:0]  data,
   output logic                  valid,
   output logic                  gt,
   output logic                  eq
);
   import upmq_pkg::*;

   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic                 valid_ff, valid_in;
   logic                 gt_ff, gt_in;
   logic                 eq_ff, eq_in;

   always_comb begin
      gt_in    = valid_ff && (prio_ff > new_prio);
      eq_in    = valid_ff && (prio_ff == new_prio);
      prio_in  = prio_ff;
      data_in  = data_ff;
      valid_in = valid_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            // left_gt high on the head cell: new item lands there unless kept
            priority if (gt_ff) begin
               prio_in = prio_ff;
               data_in = data_ff;
            end else if (left_gt) begin
               prio_in = new_prio;
               data_in = new_data;
            end else begin
               prio_in = left_prio;
               data_in = left_data;
            end
            valid_in = valid_ff || left_valid;
         end
         CELL_POP: begin
            prio_in  = right_prio;
            data_in  = right_data;
            valid_in = right_valid;
         end
         default: begin
            prio_in  = prio_ff;
            data_in  = data_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
         gt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         gt_ff    <= gt_in;
         eq_ff    <= eq_in;
      end
   end

   assign prio  = prio_ff;
   assign data  = data_ff;
   assign valid = valid_ff;
   assign gt    = gt_ff;
   assign eq    = eq_ff;

endmodule

// ===== hw/rtl/unique_priority_max_queue.sv =====
// ----------------------------------------------------------------------------
// unique_priority_max_queue: sorted queue, highest priority out first
// A chain of cells keeps entries in descending priority order, head first.
// Enqueue inserts in order and rejects duplicates or a full store; dequeue
// and peek read the head cell.
//
//   channel | dir | ports
//   req     | in  | req_valid, req_stall, req_command, req_item_priority,
//           |     | req_item_data
//   rsp     | out | rsp_valid, rsp_stall, rsp_status, rsp_out_data,
//           |     | rsp_entry_total, rsp_is_vacant
//
// Each beat passes through capture, a compare step in which every cell registers
// its compare against the new priority, then update of the chain and result.
// One beat is in work at a time; req_stall is high until the result is loaded.
// A held rsp beat only delays the update cycle.
// Synchronous reset empties the chain.
// ----------------------------------------------------------------------------
module unique_priority_max_queue #(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned PRIO_BITS = 16,
   parameter int unsigned DATA_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_command,
   input  logic [upmq_pkg::PRIO_PORT_BITS-1:0]      req_item_priority,
   input  logic [upmq_pkg::DATA_PORT_BITS-1:0]      req_item_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic [upmq_pkg::DATA_PORT_BITS-1:0]      rsp_out_data,
   output logic [upmq_pkg::TOTAL_PORT_BITS-1:0]     rsp_entry_total,
   output logic                                     rsp_is_vacant
);
   import upmq_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   fsm_type state_ff, state_in;

   cmd_type              cmd_ff;
   logic [PRIO_BITS-1:0] prio_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [CNT_BITS-1:0]  rsp_count_ff;

   cell_ctl_type         cell_ctl;
   logic [PRIO_BITS-1:0] cell_prio  [DEPTH];
   logic [DATA_BITS-1:0] cell_data  [DEPTH];
   logic [DEPTH-1:0]     cell_valid;
   logic [DEPTH-1:0]     cell_gt;
   logic [DEPTH-1:0]     cell_eq;

   logic accept_in;
   logic out_free;
   logic dup_hit;

   assign req_stall = (state_ff != FSM_IDLE);
   assign accept_in = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign dup_hit   = |cell_eq;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [PRIO_BITS-1:0] l_prio, r_prio;
         logic [DATA_BITS-1:0] l_data, r_data;
         logic                 l_valid, l_gt, r_valid;

         if (i == 0) begin : g_head
            assign l_prio  = '0;
            assign l_data  = '0;
            assign l_valid = 1'b1;
            assign l_gt    = 1'b1;
         end else begin : g_mid
            assign l_prio  = cell_prio[i-1];
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign r_prio  = '0;
            assign r_data  = '0;
            assign r_valid = 1'b0;
         end else begin : g_body
            assign r_prio  = cell_prio[i+1];
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
         end

         upmq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .DATA_BITS (DATA_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (cell_ctl),
            .new_prio    (prio_ff),
            .new_data    (data_ff),
            .left_prio   (l_prio),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_prio  (r_prio),
            .right_data  (r_data),
            .right_valid (r_valid),
            .prio        (cell_prio[i]),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i]),
            .eq          (cell_eq[i])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cell_ctl.op   = CELL_HOLD;
      rsp_status_in = STAT_OK;
      rsp_data_in   = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept_in) begin
               state_in = FSM_CMP;
            end
         end
         FSM_CMP: begin
            state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (out_free) begin
               state_in     = FSM_IDLE;
               rsp_valid_in = 1'b1;
               unique case (cmd_ff)
                  CMD_ENQ: begin
                     priority if (dup_hit) begin
                        rsp_status_in = STAT_DUP;
                     end else if (count_ff == CNT_FULL) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cell_ctl.op = CELL_INSERT;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  CMD_DEQ, CMD_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_data_in = cell_data[0];
                        if (cmd_ff == CMD_DEQ) begin
                           cell_ctl.op = CELL_POP;
                           count_in    = count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         cmd_ff  <= cmd_type'(req_command);
         prio_ff <= PRIO_BITS'(req_item_priority);
         data_ff <= DATA_BITS'(req_item_data);
      end
      if (state_ff == FSM_EXEC && out_free) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= count_in;
      end
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_data    = DATA_PORT_BITS'(rsp_data_ff);
   assign rsp_entry_total = TOTAL_PORT_BITS'(rsp_count_ff);
   assign rsp_is_vacant   = (rsp_count_ff == '0);

endmodule

// ===== tb/upmq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upmq_checker: result checker for the unique priority max queue
// Follows the req and rsp channels, keeps its own sorted copy of the store,
// predicts one result per accepted req beat and compares each rsp beat,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module upmq_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [1:0]                             req_command,
   input  logic [upmq_pkg::PRIO_PORT_BITS-1:0]    req_item_priority,
   input  logic [upmq_pkg::DATA_PORT_BITS-1:0]    req_item_data,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [1:0]                             rsp_status,
   input  logic [upmq_pkg::DATA_PORT_BITS-1:0]    rsp_out_data,
   input  logic [upmq_pkg::TOTAL_PORT_BITS-1:0]   rsp_entry_total,
   input  logic                                   rsp_is_vacant,
   output int unsigned                            error_count,
   output int unsigned                            pending_count
);
   import upmq_pkg::*;

   localparam int QUEUE_SLOTS = 16;

   typedef struct {
      status_type                  status;
      logic [DATA_PORT_BITS-1:0]   out_data;
      logic [TOTAL_PORT_BITS-1:0]  entry_total;
      logic                        is_vacant;
   } queue_reply_type;

   // ascending priority order, top entry at index held_entries-1
   logic [PRIO_PORT_BITS-1:0] sorted_prio [QUEUE_SLOTS];
   logic [DATA_PORT_BITS-1:0] sorted_word [QUEUE_SLOTS];
   int                        held_entries;
   queue_reply_type           awaited_replies [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      held_entries  = 0;
   end

   function automatic queue_reply_type predict_queue_op(cmd_type cmd,
                                                        logic [PRIO_PORT_BITS-1:0] prio,
                                                        logic [DATA_PORT_BITS-1:0] word);
      queue_reply_type r;
      int              pos;
      bit              dup;
      r.status   = STAT_OK;
      r.out_data = '0;
      pos        = 0;
      dup        = 1'b0;
      case (cmd)
         CMD_ENQ: begin
            for (int i = 0; i < held_entries; i++) begin
               if (sorted_prio[i] == prio) dup = 1'b1;
               else if (sorted_prio[i] < prio) pos = i + 1;
            end
            if (dup) begin
               r.status = STAT_DUP;
            end else if (held_entries >= QUEUE_SLOTS) begin
               r.status = STAT_FULL;
            end else begin
               for (int i = held_entries; i > pos; i--) begin
                  sorted_prio[i] = sorted_prio[i-1];
                  sorted_word[i] = sorted_word[i-1];
               end
               sorted_prio[pos] = prio;
               sorted_word[pos] = word;
               held_entries++;
            end
         end
         CMD_DEQ, CMD_PEEK: begin
            if (held_entries == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.out_data = sorted_word[held_entries-1];
               if (cmd == CMD_DEQ) held_entries--;
            end
         end
         default: ;
      endcase
      r.entry_total = TOTAL_PORT_BITS'(held_entries);
      r.is_vacant   = (held_entries == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      queue_reply_type want;
      if (reset) begin
         held_entries = 0;
         awaited_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_replies.size() == 0) begin
               $error("rsp beat with no request outstanding");
               error_count++;
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_out_data !== want.out_data) begin
                  $error("out_data: expected %h, got %h", want.out_data, rsp_out_data);
                  error_count++;
               end
               if (rsp_entry_total !== want.entry_total) begin
                  $error("entry_total: expected %0d, got %0d", want.entry_total,
                         rsp_entry_total);
                  error_count++;
               end
               if (rsp_is_vacant !== want.is_vacant) begin
                  $error("is_vacant: expected %0d, got %0d", want.is_vacant, rsp_is_vacant);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_replies.push_back(predict_queue_op(cmd_type'(req_command),
                                                       req_item_priority, req_item_data));
      end
      pending_count = awaited_replies.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the unique priority max queue
// Drives directed corner beats (empty, full, duplicates, extreme values, the
// spare command code) and then random fill/drain bursts under changing
// sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import upmq_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_BEATS   = 1850;
   localparam int          PHASE_COUNT    = 8;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_command = CMD_NOP;
   logic [PRIO_PORT_BITS-1:0]     req_item_priority = '0;
   logic [DATA_PORT_BITS-1:0]     req_item_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_status;
   logic [DATA_PORT_BITS-1:0]     rsp_out_data;
   logic [TOTAL_PORT_BITS-1:0]    rsp_entry_total;
   logic                          rsp_is_vacant;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   unique_priority_max_queue uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_item_priority (req_item_priority),
      .req_item_data     (req_item_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_data      (rsp_out_data),
      .rsp_entry_total   (rsp_entry_total),
      .rsp_is_vacant     (rsp_is_vacant)
   );

   upmq_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_item_priority (req_item_priority),
      .req_item_data     (req_item_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_data      (rsp_out_data),
      .rsp_entry_total   (rsp_entry_total),
      .rsp_is_vacant     (rsp_is_vacant),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_beat(cmd_type cmd, logic [PRIO_PORT_BITS-1:0] prio,
                            logic [DATA_PORT_BITS-1:0] word);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_item_priority <= prio;
      req_item_data     <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [PRIO_PORT_BITS-1:0] pick_priority();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return PRIO_PORT_BITS'($urandom_range(0, 31));
      if (roll < 65) return PRIO_PORT_BITS'($urandom_range(0, 3));
      if (roll < 80) return PRIO_PORT_BITS'(16'hFFFF - $urandom_range(0, 3));
      return PRIO_PORT_BITS'($urandom);
   endfunction

   task automatic random_beat(int unsigned enq_pct);
      int unsigned roll;
      cmd_type     cmd;
      roll = $urandom_range(0, 19);
      if ($urandom_range(0, 99) < enq_pct) cmd = CMD_ENQ;
      else if (roll < 12)                   cmd = CMD_DEQ;
      else if (roll < 17)                   cmd = CMD_PEEK;
      else                                  cmd = CMD_NOP;
      send_beat(cmd, pick_priority(), $urandom);
   endtask

   initial begin
      int unsigned enq_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, spare code, extremes, duplicate
      send_beat(CMD_PEEK, 16'h0000, 32'h0);
      send_beat(CMD_DEQ,  16'hFFFF, 32'hFFFF_FFFF);
      send_beat(CMD_NOP,  16'hFFFF, 32'hFFFF_FFFF);
      send_beat(CMD_ENQ,  16'hFFFF, 32'hFFFF_FFFF);
      send_beat(CMD_ENQ,  16'h0000, 32'h0000_0000);
      send_beat(CMD_ENQ,  16'hFFFF, 32'h5A5A_A5A5);
      send_beat(CMD_PEEK, 16'h0000, 32'h0);
      send_beat(CMD_DEQ,  16'h0000, 32'h0);
      // fill to capacity, then full and duplicate-while-full
      for (int k = 1; k <= 15; k++)
         send_beat(CMD_ENQ, PRIO_PORT_BITS'(k * 4000), $urandom);
      send_beat(CMD_ENQ, 16'h1234, 32'hDEAD_BEEF);
      send_beat(CMD_ENQ, 16'd4000, 32'hCAFE_F00D);

      enq_pct = 45;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 62; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 62; end
            default: begin gap_pct = 29; stall_pct = 29; end
         endcase
         for (int n = 0; n < RANDOM_BEATS / PHASE_COUNT; n++) begin
            if (n % 40 == 0) begin
               case ($urandom_range(0, 2))
                  0: enq_pct = 75;
                  1: enq_pct = 25;
                  default: enq_pct = 50;
               endcase
            end
            random_beat(enq_pct);
         end
      end
      req_valid <= 1'b0;
      stall_pct  = 0;

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
